// ===== sv/msps_pkg.sv =====
// ----------------------------------------------------------------------------
// msps_pkg
// Shared types and constants for the multi servo pulse scheduler.
// ----------------------------------------------------------------------------
package msps_pkg;

  localparam int PIN_COUNT_DEF = 16;
  localparam int PIN_W         = 4;
  localparam int FIELD_W       = 16;
  localparam int WIDTH_W       = 15;
  localparam int TICK_W        = 16;
  localparam int MODE_W        = 2;
  localparam int CFG_IDX_W     = 2;

  localparam logic [TICK_W-1:0]  END_TICK  = 16'hFFFF;
  localparam logic [TICK_W-1:0]  GAP_RST   = 16'd20;
  localparam logic [WIDTH_W-1:0] LIMIT_RST = 15'd50;

  typedef enum logic [MODE_W-1:0] {
    MODE_SET   = 2'd0,
    MODE_START = 2'd1,
    MODE_CMP   = 2'd2
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ATTACHED = 2'd0,
    CFG_GAP      = 2'd1,
    CFG_LIMIT    = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    RD_PTR  = 2'd0,
    RD_NEXT = 2'd1,
    RD_ZERO = 2'd2
  } rd_sel_t;

  typedef struct packed {
    logic    cap;
    logic    res_clr;
    logic    dec_set;
    logic    cnt_clr;
    logic    sort_step;
    logic    walk_init;
    logic    walk_step;
    logic    fin_last;
    logic    fin_sent;
    logic    start_end;
    logic    start_res;
    logic    cmp_chk;
    logic    cmp_res;
    logic    out_load;
    rd_sel_t rd_sel;
  } ctl_cmd_t;

  typedef struct packed {
    mode_t mode;
    logic  set_hit;
    logic  cnt_last;
    logic  cmp_ok;
  } dp_sts_t;

endpackage

// ===== sv/msps_dp.sv =====
// ----------------------------------------------------------------------------
// msps_dp
// Datapath: sorted width slots, schedule builder, edge store, pin levels.
// ----------------------------------------------------------------------------
module msps_dp #(
  parameter int PIN_COUNT = msps_pkg::PIN_COUNT_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [msps_pkg::MODE_W-1:0]     in_mode,
  input  logic [msps_pkg::PIN_W-1:0]      in_pin,
  input  logic [msps_pkg::WIDTH_W-1:0]    in_pulse_us,
  input  logic                            cfg_we,
  input  logic [msps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [msps_pkg::FIELD_W-1:0]    cfg_wdata,
  input  msps_pkg::ctl_cmd_t              cmd,
  output msps_pkg::dp_sts_t               sts,
  output logic [msps_pkg::FIELD_W-1:0]    out_pin_levels,
  output logic [msps_pkg::TICK_W-1:0]     out_compare_tick,
  output logic                            out_compare_armed
);
  import msps_pkg::*;

  localparam int CNT_W      = (PIN_COUNT > 1) ? $clog2(PIN_COUNT) : 1;
  localparam int EDGE_DEPTH = PIN_COUNT + 1;
  localparam int PTR_W      = $clog2(EDGE_DEPTH);
  localparam logic [FIELD_W-1:0] FIELD_MASK = FIELD_W'((32'd1 << PIN_COUNT) - 1);

  logic [FIELD_W-1:0] attached_r;
  logic [TICK_W-1:0]  gap_r;
  logic [WIDTH_W-1:0] limit_r;

  logic [MODE_W-1:0]  mode_r;
  logic [PIN_W-1:0]   pin_r;
  logic [WIDTH_W-1:0] pulse_r;

  logic [WIDTH_W-1:0] slot_w_r [PIN_COUNT];
  logic [PIN_W-1:0]   slot_p_r [PIN_COUNT];
  logic [WIDTH_W-1:0] slot_w_nxt [PIN_COUNT];
  logic [PIN_W-1:0]   slot_p_nxt [PIN_COUNT];

  logic [FIELD_W-1:0] nonzero_r;
  logic [FIELD_W-1:0] level_r;
  logic               stale_r;
  logic               live_r;
  logic [PTR_W-1:0]   ptr_r;
  logic [CNT_W-1:0]   cnt_r;

  logic [FIELD_W-1:0] drop_r;
  logic               found_r;
  logic [FIELD_W-1:0] cur_mask_r;
  logic [TICK_W-1:0]  cur_tick_r;
  logic [PTR_W-1:0]   j_r;

  logic [TICK_W-1:0]  res_tick_r;
  logic               res_armed_r;
  logic [FIELD_W-1:0] out_levels_r;
  logic [TICK_W-1:0]  out_tick_r;
  logic               out_armed_r;

  logic [FIELD_W-1:0] edge_mask_r [EDGE_DEPTH];
  logic [TICK_W-1:0]  edge_tick_r [EDGE_DEPTH];
  logic [FIELD_W-1:0] rd_mask_r;
  logic [TICK_W-1:0]  rd_tick_r;

  logic [FIELD_W-1:0] att;
  logic               pin_ok;
  logic [WIDTH_W-1:0] old_w;
  logic               set_hit;
  logic [WIDTH_W-1:0] cw;
  logic [PIN_W-1:0]   cp;
  logic [FIELD_W-1:0] cbit;
  logic [TICK_W-1:0]  ct;
  logic               near;
  logic               build;
  logic               cmp_ok;
  logic               keys_sorted;

  logic               wr_en;
  logic [PTR_W-1:0]   wr_addr;
  logic [FIELD_W-1:0] wr_mask;
  logic [TICK_W-1:0]  wr_tick;
  logic [PTR_W:0]     rd_addr;

  assign att     = attached_r & FIELD_MASK;
  assign pin_ok  = (32'(pin_r) < PIN_COUNT) && att[pin_r];
  assign set_hit = pin_ok && (old_w != pulse_r);
  assign build   = stale_r && found_r;

  // stored width of the addressed pin
  always_comb begin
    old_w = '0;
    for (int k = 0; k < PIN_COUNT; k++) begin
      if (slot_p_r[k] == pin_r) begin
        old_w = slot_w_r[k];
      end
    end
  end

  // walk of the slots in width order
  assign cw   = slot_w_r[cnt_r];
  assign cp   = slot_p_r[cnt_r];
  assign cbit = FIELD_W'(1) << cp;
  assign ct   = {cw, 1'b0};
  assign near = (ct - cur_tick_r) < gap_r;

  assign cmp_ok = live_r && (32'(ptr_r) < PIN_COUNT) && (rd_tick_r != END_TICK);

  // one odd-even transposition pass, key is width then pin
  always_comb begin
    for (int k = 0; k < PIN_COUNT; k++) begin
      slot_w_nxt[k] = slot_w_r[k];
      slot_p_nxt[k] = slot_p_r[k];
    end
    for (int k = 0; k < PIN_COUNT - 1; k++) begin
      if (((k % 2) == int'(cnt_r[0])) &&
          ({slot_w_r[k], slot_p_r[k]} > {slot_w_r[k+1], slot_p_r[k+1]})) begin
        slot_w_nxt[k]   = slot_w_r[k+1];
        slot_p_nxt[k]   = slot_p_r[k+1];
        slot_w_nxt[k+1] = slot_w_r[k];
        slot_p_nxt[k+1] = slot_p_r[k];
      end
    end
  end

  always_comb begin
    keys_sorted = 1'b1;
    for (int k = 0; k < PIN_COUNT - 1; k++) begin
      if ({slot_w_r[k], slot_p_r[k]} > {slot_w_r[k+1], slot_p_r[k+1]}) begin
        keys_sorted = 1'b0;
      end
    end
  end

  // edge store write port
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = j_r;
    wr_mask = cur_mask_r;
    wr_tick = cur_tick_r;
    if (cmd.walk_step && att[cp] && found_r && !near && stale_r) begin
      wr_en = 1'b1;
    end
    if (cmd.fin_last && build) begin
      wr_en = 1'b1;
    end
    if (cmd.fin_sent && build) begin
      wr_en   = 1'b1;
      wr_addr = j_r + PTR_W'(1);
      wr_tick = END_TICK;
    end
  end

  always_comb begin
    case (cmd.rd_sel)
      RD_PTR:  rd_addr = {1'b0, ptr_r};
      RD_NEXT: rd_addr = {1'b0, ptr_r} + (PTR_W+1)'(1);
      RD_ZERO: rd_addr = '0;
      default: rd_addr = {1'b0, ptr_r};
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      edge_mask_r[wr_addr] <= wr_mask;
      edge_tick_r[wr_addr] <= wr_tick;
    end
    if (32'(rd_addr) < EDGE_DEPTH) begin
      rd_mask_r <= edge_mask_r[rd_addr[PTR_W-1:0]];
      rd_tick_r <= edge_tick_r[rd_addr[PTR_W-1:0]];
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      mode_r  <= in_mode;
      pin_r   <= in_pin;
      pulse_r <= in_pulse_us;
    end
    if (cmd.walk_step && att[cp]) begin
      if (!found_r) begin
        if (cw >= limit_r) begin
          cur_mask_r <= drop_r | cbit;
          cur_tick_r <= ct;
        end
      end else if (near) begin
        cur_mask_r <= cur_mask_r | cbit;
      end else begin
        cur_mask_r <= cur_mask_r | cbit;
        cur_tick_r <= ct;
      end
    end
    if (cmd.out_load) begin
      out_levels_r <= level_r;
      out_tick_r   <= res_tick_r;
      out_armed_r  <= res_armed_r;
    end
  end

  // control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attached_r  <= '0;
      gap_r       <= GAP_RST;
      limit_r     <= LIMIT_RST;
      for (int k = 0; k < PIN_COUNT; k++) begin
        slot_w_r[k] <= '0;
        slot_p_r[k] <= PIN_W'(k);
      end
      nonzero_r   <= '0;
      level_r     <= '0;
      stale_r     <= 1'b1;
      live_r      <= 1'b0;
      ptr_r       <= '0;
      cnt_r       <= '0;
      drop_r      <= '0;
      found_r     <= 1'b0;
      j_r         <= '0;
      res_tick_r  <= '0;
      res_armed_r <= 1'b0;
    end else begin
      if (cmd.cnt_clr) begin
        cnt_r <= '0;
      end else if (cmd.sort_step || cmd.walk_step) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end
      if (cmd.res_clr) begin
        res_tick_r  <= '0;
        res_armed_r <= 1'b0;
      end
      if (cmd.dec_set && set_hit) begin
        for (int k = 0; k < PIN_COUNT; k++) begin
          if (slot_p_r[k] == pin_r) begin
            slot_w_r[k] <= pulse_r;
          end
        end
        nonzero_r[pin_r] <= (pulse_r != '0);
        stale_r          <= 1'b1;
      end
      if (cmd.sort_step) begin
        for (int k = 0; k < PIN_COUNT; k++) begin
          slot_w_r[k] <= slot_w_nxt[k];
          slot_p_r[k] <= slot_p_nxt[k];
        end
      end
      if (cmd.walk_init) begin
        drop_r  <= '0;
        found_r <= 1'b0;
        j_r     <= '0;
      end
      if (cmd.walk_step && att[cp]) begin
        if (!found_r) begin
          if (cw < limit_r) begin
            drop_r <= drop_r | cbit;
          end else begin
            found_r <= 1'b1;
            j_r     <= '0;
          end
        end else if (!near) begin
          j_r <= j_r + PTR_W'(1);
        end
      end
      if (cmd.start_end) begin
        level_r <= (level_r | (att & nonzero_r)) & ~(drop_r & att);
        stale_r <= 1'b0;
        ptr_r   <= '0;
        live_r  <= found_r;
      end
      if (cmd.start_res) begin
        res_tick_r  <= found_r ? rd_tick_r : '0;
        res_armed_r <= found_r;
      end
      if (cmd.cmp_chk) begin
        if (cmp_ok) begin
          level_r <= level_r & ~(rd_mask_r & att);
          ptr_r   <= ptr_r + PTR_W'(1);
        end else begin
          live_r <= 1'b0;
        end
      end
      if (cmd.cmp_res) begin
        res_tick_r  <= rd_tick_r;
        res_armed_r <= 1'b1;
        if (rd_tick_r == END_TICK) begin
          live_r <= 1'b0;
        end
      end
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_ATTACHED: begin
            attached_r <= cfg_wdata;
            stale_r    <= 1'b1;
          end
          CFG_GAP: begin
            gap_r   <= cfg_wdata;
            stale_r <= 1'b1;
          end
          CFG_LIMIT: begin
            limit_r <= cfg_wdata[WIDTH_W-1:0];
            stale_r <= 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

  assign sts.mode     = mode_t'(mode_r);
  assign sts.set_hit  = set_hit;
  assign sts.cnt_last = (cnt_r == CNT_W'(PIN_COUNT - 1));
  assign sts.cmp_ok   = cmp_ok;

  assign out_pin_levels    = out_levels_r;
  assign out_compare_tick  = out_tick_r;
  assign out_compare_armed = out_armed_r;

  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(ptr_r) <= PIN_COUNT)
    else $error("edge pointer beyond the list");

  a_sorted_at_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> keys_sorted)
    else $error("width slots out of order when a result is issued");

  a_write_range: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (32'(wr_addr) < EDGE_DEPTH))
    else $error("edge store write outside its depth");

endmodule

// ===== sv/msps_ctrl.sv =====
// ----------------------------------------------------------------------------
// msps_ctrl
// Controller: sequences the set, cycle-start and compare transactions.
// ----------------------------------------------------------------------------
module msps_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  msps_pkg::dp_sts_t  sts,
  output msps_pkg::ctl_cmd_t cmd
);
  import msps_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b000_0000_0001,
    S_DEC   = 11'b000_0000_0010,
    S_SORT  = 11'b000_0000_0100,
    S_WALK  = 11'b000_0000_1000,
    S_FIN0  = 11'b000_0001_0000,
    S_FIN1  = 11'b000_0010_0000,
    S_STEND = 11'b000_0100_0000,
    S_STRD  = 11'b000_1000_0000,
    S_CMP1  = 11'b001_0000_0000,
    S_CMP2  = 11'b010_0000_0000,
    S_OUT   = 11'b100_0000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    cmd.rd_sel    = RD_PTR;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd.cap   = 1'b1;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        cmd.res_clr = 1'b1;
        cmd.cnt_clr = 1'b1;
        case (sts.mode)
          MODE_SET: begin
            cmd.dec_set = 1'b1;
            state_nxt   = sts.set_hit ? S_SORT : S_OUT;
          end
          MODE_START: begin
            cmd.walk_init = 1'b1;
            state_nxt     = S_WALK;
          end
          MODE_CMP: begin
            cmd.rd_sel = RD_PTR;
            state_nxt  = S_CMP1;
          end
          default: state_nxt = S_OUT;
        endcase
      end
      S_SORT: begin
        cmd.sort_step = 1'b1;
        if (sts.cnt_last) begin
          state_nxt = S_OUT;
        end
      end
      S_WALK: begin
        cmd.walk_step = 1'b1;
        if (sts.cnt_last) begin
          state_nxt = S_FIN0;
        end
      end
      S_FIN0: begin
        cmd.fin_last = 1'b1;
        state_nxt    = S_FIN1;
      end
      S_FIN1: begin
        cmd.fin_sent = 1'b1;
        state_nxt    = S_STEND;
      end
      S_STEND: begin
        cmd.start_end = 1'b1;
        cmd.rd_sel    = RD_ZERO;
        state_nxt     = S_STRD;
      end
      S_STRD: begin
        cmd.start_res = 1'b1;
        state_nxt     = S_OUT;
      end
      S_CMP1: begin
        cmd.cmp_chk = 1'b1;
        cmd.rd_sel  = RD_NEXT;
        state_nxt   = sts.cmp_ok ? S_CMP2 : S_OUT;
      end
      S_CMP2: begin
        cmd.cmp_res = 1'b1;
        state_nxt   = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == S_DEC))
    else $error("accepted transaction not decoded");

  a_out_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && out_valid_r && out_stall) |=> (state_r == S_OUT))
    else $error("result left while output register still full");

  a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_OUT))
    else $error("result shown without passing the output state");

endmodule

// ===== sv/multi_servo_pulse_scheduler.sv =====
// ----------------------------------------------------------------------------
// multi_servo_pulse_scheduler
// Servo pulse scheduler for up to 16 pins sharing one compare timer.
// ----------------------------------------------------------------------------
//  channel  direction  handshake            payload
//  in       input      in_valid / in_stall  in_mode, in_pin, in_pulse_us
//  out      output     out_valid/out_stall  out_pin_levels, out_compare_tick,
//                                           out_compare_armed
//  cfg      input      cfg_we               cfg_index, cfg_wdata
//
// one transaction at a time: set runs odd-even sort passes over the width
// slots when the width changes; cycle start walks the sorted list one slot
// per cycle; compare reads the registered edge store. synchronous active-low
// reset; the result sits in an output register so the next transaction is
// taken while it is stalled.
// ----------------------------------------------------------------------------
module multi_servo_pulse_scheduler #(
  parameter int PIN_COUNT = msps_pkg::PIN_COUNT_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [msps_pkg::MODE_W-1:0]     in_mode,
  input  logic [msps_pkg::PIN_W-1:0]      in_pin,
  input  logic [msps_pkg::WIDTH_W-1:0]    in_pulse_us,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [msps_pkg::FIELD_W-1:0]    out_pin_levels,
  output logic [msps_pkg::TICK_W-1:0]     out_compare_tick,
  output logic                            out_compare_armed,
  input  logic                            cfg_we,
  input  logic [msps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [msps_pkg::FIELD_W-1:0]    cfg_wdata
);
  import msps_pkg::*;

  ctl_cmd_t cmd;
  dp_sts_t  sts;

  msps_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  msps_dp #(
    .PIN_COUNT (PIN_COUNT)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_mode           (in_mode),
    .in_pin            (in_pin),
    .in_pulse_us       (in_pulse_us),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .cmd               (cmd),
    .sts               (sts),
    .out_pin_levels    (out_pin_levels),
    .out_compare_tick  (out_compare_tick),
    .out_compare_armed (out_compare_armed)
  );

endmodule
